FILE: rtl/uart_oversample_baud_divisor_search_unit_macros.svh
// assertion macros shared by the baud divisor search unit
// no dependencies; included by the files that carry assertions
`ifndef UART_OVERSAMPLE_BAUD_DIVISOR_SEARCH_UNIT_MACROS_SVH
`define UART_OVERSAMPLE_BAUD_DIVISOR_SEARCH_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define UOSD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define UOSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/uosd_pkg.sv
// types and constants of the baud divisor search unit
// no dependencies; used by every other file of the block but the macro header
package uosd_pkg;

   localparam int CLOCK_W  = 26;
   localparam int BAUD_W   = 24;
   localparam int RATIO_W  = 6;
   localparam int DIVOUT_W = 13;
   localparam int STATUS_W = 2;

   // serial divider geometry
   localparam int DIVD_W   = 26;
   localparam int DIVR_W   = 30;
   localparam int STEP_W   = 5;

   // prescale divisor of an accepted clock fits 24 bits, bound fits 20 bits
   localparam int PRE_W    = 24;
   localparam int RATE_W   = 26;
   localparam int BOUND_W  = 20;

   // divide by 100 as a shift by two and a multiply by the reciprocal of 25
   localparam int RECIP_W      = 23;
   localparam int RECIP_SHIFT  = 27;
   localparam int RECIP_PROD_W = BAUD_W - 2 + RECIP_W;

   localparam logic [CLOCK_W-1:0]  CLOCK_MAX     = 26'd50000000;
   localparam logic [CLOCK_W-1:0]  CLOCK_MIN     = 26'd32000;
   localparam logic [RECIP_W-1:0]  RECIP_25      = 23'd5368710;
   localparam logic [BOUND_W-1:0]  BOUND_SCALE   = 20'd3;
   localparam logic [RATIO_W-1:0]  MIN_RATIO     = 6'd4;
   localparam logic [RATIO_W-1:0]  EDGE_LIMIT    = 6'd9;
   localparam logic [DIVOUT_W-1:0] DIV_MAX       = 13'h1FFF;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_CLOCK = 2'd1,
      STATUS_BIG_ERROR = 2'd2,
      STATUS_DIV_RANGE = 2'd3
   } uosd_status_type;

   typedef enum logic {
      OP_PRESCALE,
      OP_RATE
   } uosd_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_PRESCALE,
      S_WAIT_PRESCALE,
      S_RATE,
      S_WAIT_RATE,
      S_SCORE,
      S_FINISH
   } uosd_state_type;

   typedef struct packed {
      logic        load;
      logic        div_start;
      uosd_op_type op_sel;
      logic        latch_bound;
      logic        latch_prescale;
      logic        latch_rate;
      logic        score;
      logic        ratio_init;
      logic        emit;
   } uosd_cmd_type;

   typedef struct packed {
      logic clock_bad;
      logic div_done;
      logic ratio_last;
      logic rsp_free;
   } uosd_stat_type;

endpackage

FILE: rtl/uosd_ifs.sv
// valid/ready channel interfaces of the baud divisor search unit
// depends on uosd_pkg for field widths
interface uosd_req_if;
   logic                          valid;
   logic                          ready;
   logic [uosd_pkg::CLOCK_W-1:0]  clock_hz;
   logic [uosd_pkg::BAUD_W-1:0]   baud_target;

   modport source (output valid, output clock_hz, output baud_target, input ready);
   modport sink   (input valid, input clock_hz, input baud_target, output ready);
endinterface

interface uosd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [uosd_pkg::RATIO_W-1:0]  oversample_ratio;
   logic [uosd_pkg::DIVOUT_W-1:0] baud_divisor;
   logic                          both_edge;
   logic [uosd_pkg::STATUS_W-1:0] status;

   modport source (output valid, output oversample_ratio, output baud_divisor,
                   output both_edge, output status, input ready);
   modport sink   (input valid, input oversample_ratio, input baud_divisor,
                   input both_edge, input status, output ready);
endinterface

FILE: rtl/uosd_div.sv
// restoring serial divider, one quotient bit per cycle
// depends on uosd_pkg and the assertion macro header
`include "uart_oversample_baud_divisor_search_unit_macros.svh"

module uosd_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [uosd_pkg::DIVD_W-1:0] dividend,
   input  logic [uosd_pkg::DIVR_W-1:0] divisor,
   output logic                        done,
   output logic [uosd_pkg::DIVD_W-1:0] quotient
);

   logic [uosd_pkg::DIVD_W-1:0] quo_ff, quo_in;
   logic [uosd_pkg::DIVD_W-1:0] rem_ff, rem_in;
   logic [uosd_pkg::DIVR_W-1:0] dvs_ff, dvs_in;
   logic [uosd_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic                        zero_ff, zero_in;

   logic [uosd_pkg::DIVD_W:0]   trial;
   logic [uosd_pkg::DIVD_W:0]   diff;
   logic                        fits;
   logic                        last_step;

   // shift next dividend bit into the partial remainder
   assign trial     = {rem_ff, quo_ff[uosd_pkg::DIVD_W-1]};
   assign fits      = uosd_pkg::DIVR_W'(trial) >= dvs_ff;
   assign diff      = trial - dvs_ff[uosd_pkg::DIVD_W:0];
   assign last_step = cnt_ff == uosd_pkg::STEP_W'(uosd_pkg::DIVD_W - 1);

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         zero_in = divisor == '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[uosd_pkg::DIVD_W-1:0] : trial[uosd_pkg::DIVD_W-1:0];
         quo_in = {quo_ff[uosd_pkg::DIVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
   end

   // a zero divisor yields a zero quotient
   assign done     = done_ff;
   assign quotient = zero_ff ? '0 : quo_ff;

   `UOSD_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff, "divider did not start")
   `UOSD_ASSERT_SAME(a_done_idle, clock, reset, done_ff, !busy_ff, "done while still busy")
   `UOSD_ASSERT_NEXT(a_keep_busy, clock, reset, busy_ff && !last_step && !start, busy_ff,
                     "divider stopped early")

endmodule

FILE: rtl/uosd_dpath.sv
// datapath of the baud divisor search: operand select, best-ratio tracking,
// result register; depends on uosd_pkg and uosd_div
module uosd_dpath #(
   parameter int MAX_RATIO = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  uosd_pkg::uosd_cmd_type        cmd,
   output uosd_pkg::uosd_stat_type       stat,
   input  logic [uosd_pkg::CLOCK_W-1:0]  req_clock_hz,
   input  logic [uosd_pkg::BAUD_W-1:0]   req_baud_target,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [uosd_pkg::RATIO_W-1:0]  rsp_oversample_ratio,
   output logic [uosd_pkg::DIVOUT_W-1:0] rsp_baud_divisor,
   output logic                          rsp_both_edge,
   output logic [uosd_pkg::STATUS_W-1:0] rsp_status
);

   logic [uosd_pkg::CLOCK_W-1:0]  clk_ff;
   logic [uosd_pkg::BAUD_W-1:0]   baud_ff;
   logic [uosd_pkg::BOUND_W-1:0]  bound_ff;
   logic [uosd_pkg::RATIO_W-1:0]  ratio_ff, ratio_in;
   logic [uosd_pkg::PRE_W-1:0]    pre_ff;
   logic [uosd_pkg::RATE_W-1:0]   rate_ff;
   logic [uosd_pkg::RATE_W-1:0]   best_err_ff;
   logic [uosd_pkg::PRE_W-1:0]    best_div_ff;
   logic [uosd_pkg::RATIO_W-1:0]  best_ratio_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [uosd_pkg::RATIO_W-1:0]  out_ratio_ff, out_ratio_in;
   logic [uosd_pkg::DIVOUT_W-1:0] out_div_ff, out_div_in;
   logic                          out_edge_ff, out_edge_in;
   uosd_pkg::uosd_status_type     out_status_ff, out_status_in;

   logic [uosd_pkg::DIVD_W-1:0]       dividend;
   logic [uosd_pkg::DIVR_W-1:0]       divisor;
   logic [uosd_pkg::DIVD_W-1:0]       quotient;
   logic                              div_done;
   logic [uosd_pkg::RECIP_PROD_W-1:0] recip_prod;
   logic [uosd_pkg::BOUND_W-1:0]      bound_prod;
   logic [uosd_pkg::RATE_W-1:0]       baud_ext;
   logic [uosd_pkg::RATE_W-1:0]       err;
   logic                              take;
   logic                              clock_bad;

   // operands of the shared divider
   assign dividend = clk_ff;

   always_comb begin
      unique case (cmd.op_sel)
         uosd_pkg::OP_PRESCALE: begin
            divisor = uosd_pkg::DIVR_W'(baud_ff) * uosd_pkg::DIVR_W'(ratio_ff);
         end
         uosd_pkg::OP_RATE: begin
            divisor = uosd_pkg::DIVR_W'(ratio_ff) * uosd_pkg::DIVR_W'(pre_ff);
         end
      endcase
   end

   uosd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // error bound (baud / 100) * 3, quotient by 100 exact over the whole target field
   assign recip_prod = uosd_pkg::RECIP_PROD_W'(baud_ff[uosd_pkg::BAUD_W-1:2]) *
                       uosd_pkg::RECIP_PROD_W'(uosd_pkg::RECIP_25);
   assign bound_prod = uosd_pkg::BOUND_W'(
                          recip_prod[uosd_pkg::RECIP_PROD_W-1:uosd_pkg::RECIP_SHIFT]) *
                       uosd_pkg::BOUND_SCALE;
   assign baud_ext   = uosd_pkg::RATE_W'(baud_ff);
   assign err        = (rate_ff > baud_ext) ? rate_ff - baud_ext : baud_ext - rate_ff;
   assign take       = (ratio_ff == uosd_pkg::MIN_RATIO) || (err <= best_err_ff);
   assign clock_bad  = (clk_ff > uosd_pkg::CLOCK_MAX) || (clk_ff < uosd_pkg::CLOCK_MIN);

   always_comb begin
      ratio_in = ratio_ff;
      if (cmd.ratio_init) begin
         ratio_in = uosd_pkg::MIN_RATIO;
      end else if (cmd.score) begin
         ratio_in = ratio_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         clk_ff  <= req_clock_hz;
         baud_ff <= req_baud_target;
      end
      if (cmd.latch_bound) begin
         bound_ff <= bound_prod;
      end
      if (cmd.latch_prescale) begin
         pre_ff <= quotient[uosd_pkg::PRE_W-1:0];
      end
      if (cmd.latch_rate) begin
         rate_ff <= quotient[uosd_pkg::RATE_W-1:0];
      end
      if (cmd.score && take) begin
         best_err_ff   <= err;
         best_div_ff   <= pre_ff;
         best_ratio_ff <= ratio_ff;
      end
      ratio_ff <= ratio_in;
   end

   // final result
   always_comb begin
      out_ratio_in  = best_ratio_ff;
      out_edge_in   = best_ratio_ff < uosd_pkg::EDGE_LIMIT;
      out_div_in    = (best_div_ff > uosd_pkg::PRE_W'(uosd_pkg::DIV_MAX)) ?
                      uosd_pkg::DIV_MAX : best_div_ff[uosd_pkg::DIVOUT_W-1:0];
      if (clock_bad) begin
         out_ratio_in  = '0;
         out_edge_in   = 1'b0;
         out_div_in    = '0;
         out_status_in = uosd_pkg::STATUS_BAD_CLOCK;
      end else if (!(best_err_ff < uosd_pkg::RATE_W'(bound_ff))) begin
         out_status_in = uosd_pkg::STATUS_BIG_ERROR;
      end else if (best_div_ff == '0 ||
                   best_div_ff > uosd_pkg::PRE_W'(uosd_pkg::DIV_MAX)) begin
         out_status_in = uosd_pkg::STATUS_DIV_RANGE;
      end else begin
         out_status_in = uosd_pkg::STATUS_OK;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.emit) begin
         out_ratio_ff  <= out_ratio_in;
         out_div_ff    <= out_div_in;
         out_edge_ff   <= out_edge_in;
         out_status_ff <= out_status_in;
      end
   end

   assign stat.clock_bad  = clock_bad;
   assign stat.div_done   = div_done;
   assign stat.ratio_last = ratio_ff == uosd_pkg::RATIO_W'(MAX_RATIO);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_oversample_ratio = out_ratio_ff;
   assign rsp_baud_divisor     = out_div_ff;
   assign rsp_both_edge        = out_edge_ff;
   assign rsp_status           = out_status_ff;

endmodule

FILE: rtl/uosd_ctrl.sv
// sequencer of the baud divisor search: latches the error bound, then walks
// prescale and rate divisions for each ratio; depends on uosd_pkg and the macro header
`include "uart_oversample_baud_divisor_search_unit_macros.svh"

module uosd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  uosd_pkg::uosd_stat_type stat,
   output uosd_pkg::uosd_cmd_type  cmd
);

   uosd_pkg::uosd_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uosd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.op_sel = uosd_pkg::OP_PRESCALE;
      req_ready  = 1'b0;
      unique case (state_ff)
         uosd_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = uosd_pkg::S_CHECK;
            end
         end
         uosd_pkg::S_CHECK: begin
            if (stat.clock_bad) begin
               state_in = uosd_pkg::S_FINISH;
            end else begin
               cmd.latch_bound = 1'b1;
               cmd.ratio_init  = 1'b1;
               state_in        = uosd_pkg::S_PRESCALE;
            end
         end
         uosd_pkg::S_PRESCALE: begin
            cmd.op_sel    = uosd_pkg::OP_PRESCALE;
            cmd.div_start = 1'b1;
            state_in      = uosd_pkg::S_WAIT_PRESCALE;
         end
         uosd_pkg::S_WAIT_PRESCALE: begin
            if (stat.div_done) begin
               cmd.latch_prescale = 1'b1;
               state_in           = uosd_pkg::S_RATE;
            end
         end
         uosd_pkg::S_RATE: begin
            cmd.op_sel    = uosd_pkg::OP_RATE;
            cmd.div_start = 1'b1;
            state_in      = uosd_pkg::S_WAIT_RATE;
         end
         uosd_pkg::S_WAIT_RATE: begin
            if (stat.div_done) begin
               cmd.latch_rate = 1'b1;
               state_in       = uosd_pkg::S_SCORE;
            end
         end
         uosd_pkg::S_SCORE: begin
            cmd.score = 1'b1;
            state_in  = stat.ratio_last ? uosd_pkg::S_FINISH : uosd_pkg::S_PRESCALE;
         end
         uosd_pkg::S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = uosd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = uosd_pkg::S_IDLE;
         end
      endcase
   end

   `UOSD_ASSERT_SAME(a_done_expected, clock, reset, stat.div_done,
                     state_ff == uosd_pkg::S_WAIT_PRESCALE || state_ff == uosd_pkg::S_WAIT_RATE,
                     "divider done outside a wait state")
   `UOSD_ASSERT_SAME(a_emit_free, clock, reset, cmd.emit, stat.rsp_free,
                     "result loaded over a pending transfer")
   `UOSD_ASSERT_NEXT(a_bad_clock_skip, clock, reset,
                     state_ff == uosd_pkg::S_CHECK && stat.clock_bad,
                     state_ff == uosd_pkg::S_FINISH, "bad clock did not skip the search")

endmodule

FILE: rtl/uart_oversample_baud_divisor_search_unit.sv
// top level of the uart baud divisor and oversampling ratio search
// depends on uosd_pkg, uosd_ifs, uosd_ctrl, uosd_dpath and uosd_div
//
// Each request transfer carries the module clock in Hz and the wanted baud
// rate; one response transfer follows with the oversampling ratio, the 13-bit
// divisor, the both-edge flag (ratio 4 to 8) and a status (ok, clock outside
// 32000..50000000 Hz, best error not below (baud / 100 rounded down) * 3,
// divisor zero or above 8191 and then reported saturated). Every ratio from 4
// to MAX_RATIO is tried; the one with the smallest rate error wins, a later
// ratio winning a tie. The error bound is formed with a shift and a reciprocal
// multiply. The two divisions of each ratio go through one restoring serial
// divider that produces one quotient bit per clock. The error bound is latched
// first, then each ratio runs its two divisions, each started and then waited
// on, and is scored. A bad clock skips the search and goes straight to the
// response. One request is worked at a time; the next request is taken as
// soon as the result is in the output register, even if the response has
// not been transferred yet.
module uart_oversample_baud_divisor_search_unit #(
   parameter int MAX_RATIO = 32
) (
   input  logic       clock,
   input  logic       reset,
   uosd_req_if.sink   req,
   uosd_rsp_if.source rsp
);

   // command and status bundles between sequencer and datapath
   uosd_pkg::uosd_cmd_type  cmd;
   uosd_pkg::uosd_stat_type stat;

   // sequencer: a start and a wait state per division and a score state per ratio
   uosd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: operand select, serial divider, best-ratio tracking, result
   uosd_dpath #(
      .MAX_RATIO (MAX_RATIO)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_clock_hz         (req.clock_hz),
      .req_baud_target      (req.baud_target),
      .rsp_ready            (rsp.ready),
      .rsp_valid            (rsp.valid),
      .rsp_oversample_ratio (rsp.oversample_ratio),
      .rsp_baud_divisor     (rsp.baud_divisor),
      .rsp_both_edge        (rsp.both_edge),
      .rsp_status           (rsp.status)
   );

endmodule
